/* rtl/spc_pkg.sv */
package spc_pkg;

    // Pixel and result field widths
    localparam int CHAN_W  = 8;
    localparam int LEVEL_W = 2;
    localparam int MASK_W  = 8;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 19;
    localparam int OFFSET_W   = 19;
    localparam int LUMA_REF_W = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_UPPER_LINE1 = 3'd0,
        REG_UPPER_LINE2 = 3'd1,
        REG_LOWER_LINE1 = 3'd2,
        REG_LOWER_LINE2 = 3'd3,
        REG_LUMA_REF    = 3'd4
    } cfg_reg_t;

    // Slopes are Q8, range -4096..4095
    localparam int SLOPE_W            = 13;
    localparam int UP_SLOPE1_DEFAULT  = 256;
    localparam int UP_SLOPE2_DEFAULT  = 256;
    localparam int DOWN_SLOPE1_DEFAULT = 256;
    localparam int DOWN_SLOPE2_DEFAULT = 256;

    // Colour conversion, coefficients in Q16
    localparam int SUM_W = 24;
    localparam int Q8_W  = 16;
    localparam logic [SUM_W-1:0] KY_B  = 24'd7471;
    localparam logic [SUM_W-1:0] KY_G  = 24'd38470;
    localparam logic [SUM_W-1:0] KY_R  = 24'd19595;
    localparam logic [SUM_W-1:0] KCR_B = 24'd5328;
    localparam logic [SUM_W-1:0] KCR_G = 24'd27440;
    localparam logic [SUM_W-1:0] KCR_R = 24'd32768;
    localparam logic [SUM_W-1:0] KCB_B = 24'd32768;
    localparam logic [SUM_W-1:0] KCB_G = 24'd21712;
    localparam logic [SUM_W-1:0] KCB_R = 24'd11056;
    localparam logic [SUM_W-1:0] CHROMA_OFS = 24'd8388608;
    localparam logic [SUM_W:0]   ROUND_HALF = 25'd128;

    // Line values in Q16
    localparam int LINE_W = 32;

    // Luma tolerance, 15.0 in Q8.8
    localparam int LUMA_D_W = 18;
    localparam logic signed [LUMA_D_W-1:0] LUMA_TOL = 18'sd3840;

    localparam logic [LEVEL_W-1:0] LEVEL_NONE = 2'd0;
    localparam logic [LEVEL_W-1:0] LEVEL_FAR  = 2'd1;
    localparam logic [LEVEL_W-1:0] LEVEL_NEAR = 2'd2;

    localparam logic [MASK_W-1:0] MASK_ON  = 8'hFF;
    localparam logic [MASK_W-1:0] MASK_OFF = 8'h00;

endpackage

/* rtl/skin_pixel_classifier.sv */
// Channel   Direction  Handshake           Payload
// s_axis    in         s_tvalid/s_tready   blue, green, red (24-bit tdata)
// m_axis    out        m_tvalid/m_tready   skin_level, mask_byte (16-bit tdata)
// cfg       in         cfg_wen             cfg_index, cfg_wdata
//
// One pixel a cycle while the output is not stalled (four register stages:
// colour sums, Q8.8 rounding, line values and luma distance, classification).
// Each stage holds only while its successor is full and stalled, so bubbles
// are squeezed out and an input is taken while a result waits at the output.
// rst_n clears valid bits and configuration registers at once.
module skin_pixel_classifier #(
    parameter int UP_SLOPE1_Q8   = spc_pkg::UP_SLOPE1_DEFAULT,
    parameter int UP_SLOPE2_Q8   = spc_pkg::UP_SLOPE2_DEFAULT,
    parameter int DOWN_SLOPE1_Q8 = spc_pkg::DOWN_SLOPE1_DEFAULT,
    parameter int DOWN_SLOPE2_Q8 = spc_pkg::DOWN_SLOPE2_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [23:0]                      s_tdata,   // blue, green, red
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [15:0]                      m_tdata,   // skin_level, mask_byte, zero pad
    input  logic                             cfg_wen,
    input  logic [spc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [spc_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    localparam int SW = spc_pkg::SLOPE_W;
    localparam int LW = spc_pkg::LINE_W;
    localparam int SUMW = spc_pkg::SUM_W;
    localparam int QW = spc_pkg::Q8_W;
    localparam int DW = spc_pkg::LUMA_D_W;

    localparam logic signed [SW-1:0] SLOPE_U1 = SW'(UP_SLOPE1_Q8);
    localparam logic signed [SW-1:0] SLOPE_U2 = SW'(UP_SLOPE2_Q8);
    localparam logic signed [SW-1:0] SLOPE_D1 = SW'(DOWN_SLOPE1_Q8);
    localparam logic signed [SW-1:0] SLOPE_D2 = SW'(DOWN_SLOPE2_Q8);

    // configuration
    logic signed [spc_pkg::OFFSET_W-1:0] up1_ofs_reg, up2_ofs_reg;
    logic signed [spc_pkg::OFFSET_W-1:0] dn1_ofs_reg, dn2_ofs_reg;
    logic [spc_pkg::LUMA_REF_W-1:0]      luma_ref_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            up1_ofs_reg  <= '0;
            up2_ofs_reg  <= '0;
            dn1_ofs_reg  <= '0;
            dn2_ofs_reg  <= '0;
            luma_ref_reg <= '0;
        end
        else if (cfg_wen)
        begin
            unique case (cfg_index)
                spc_pkg::REG_UPPER_LINE1: up1_ofs_reg  <= $signed(cfg_wdata);
                spc_pkg::REG_UPPER_LINE2: up2_ofs_reg  <= $signed(cfg_wdata);
                spc_pkg::REG_LOWER_LINE1: dn1_ofs_reg  <= $signed(cfg_wdata);
                spc_pkg::REG_LOWER_LINE2: dn2_ofs_reg  <= $signed(cfg_wdata);
                spc_pkg::REG_LUMA_REF:    luma_ref_reg <= cfg_wdata[spc_pkg::LUMA_REF_W-1:0];
                default: ;
            endcase
        end
    end

    // stage flow control
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic en1, en2, en3, en4;

    assign en4 = !v4_reg || m_tready;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign s_tready = en1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (en1) v1_reg <= s_tvalid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
        end
    end

    // stage 1: weighted colour sums in Q16
    logic [spc_pkg::CHAN_W-1:0] blue, green, red;
    logic [SUMW-1:0] y_sum_next, cr_sum_next, cb_sum_next;
    logic [SUMW-1:0] y_sum_reg, cr_sum_reg, cb_sum_reg;

    assign blue  = s_tdata[7:0];
    assign green = s_tdata[15:8];
    assign red   = s_tdata[23:16];

    // intermediate terms may wrap; every final sum lies within 0..2^24-1
    always_comb
    begin
        y_sum_next  = spc_pkg::KY_B * SUMW'(blue) + spc_pkg::KY_G * SUMW'(green)
                    + spc_pkg::KY_R * SUMW'(red);
        cr_sum_next = spc_pkg::CHROMA_OFS - spc_pkg::KCR_B * SUMW'(blue)
                    - spc_pkg::KCR_G * SUMW'(green) + spc_pkg::KCR_R * SUMW'(red);
        cb_sum_next = spc_pkg::CHROMA_OFS + spc_pkg::KCB_B * SUMW'(blue)
                    - spc_pkg::KCB_G * SUMW'(green) - spc_pkg::KCB_R * SUMW'(red);
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            y_sum_reg  <= y_sum_next;
            cr_sum_reg <= cr_sum_next;
            cb_sum_reg <= cb_sum_next;
        end
    end

    // stage 2: round to nearest Q8.8
    logic [SUMW:0] y_rnd, cr_rnd, cb_rnd;
    logic [QW-1:0] y_q8_reg, cr_q8_reg, cb_q8_reg;

    assign y_rnd  = {1'b0, y_sum_reg}  + spc_pkg::ROUND_HALF;
    assign cr_rnd = {1'b0, cr_sum_reg} + spc_pkg::ROUND_HALF;
    assign cb_rnd = {1'b0, cb_sum_reg} + spc_pkg::ROUND_HALF;

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            y_q8_reg  <= y_rnd[SUMW-1:8];
            cr_q8_reg <= cr_rnd[SUMW-1:8];
            cb_q8_reg <= cb_rnd[SUMW-1:8];
        end
    end

    // stage 3: line values in Q16 and signed luma distance
    logic signed [LW-1:0] cb_s, cr_q16_next;
    logic signed [LW-1:0] up1_next, up2_next, dn1_next, dn2_next;
    logic signed [DW-1:0] luma_d;
    logic                 near_next;
    logic signed [LW-1:0] up1_reg, up2_reg, dn1_reg, dn2_reg, cr_q16_reg;
    logic                 near_reg;

    always_comb
    begin
        cb_s        = LW'($signed({1'b0, cb_q8_reg}));
        cr_q16_next = LW'($signed({1'b0, cr_q8_reg, 8'b0}));
        up1_next    = LW'(SLOPE_U1) * cb_s + (LW'(up1_ofs_reg) <<< 8);
        up2_next    = LW'(SLOPE_U2) * cb_s + (LW'(up2_ofs_reg) <<< 8);
        dn1_next    = LW'(SLOPE_D1) * cb_s + (LW'(dn1_ofs_reg) <<< 8);
        dn2_next    = LW'(SLOPE_D2) * cb_s + (LW'(dn2_ofs_reg) <<< 8);
        luma_d      = $signed({2'b0, y_q8_reg}) - $signed({2'b0, luma_ref_reg, 8'b0});
        near_next   = (luma_d > -spc_pkg::LUMA_TOL) && (luma_d < spc_pkg::LUMA_TOL);
    end

    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            up1_reg    <= up1_next;
            up2_reg    <= up2_next;
            dn1_reg    <= dn1_next;
            dn2_reg    <= dn2_next;
            cr_q16_reg <= cr_q16_next;
            near_reg   <= near_next;
        end
    end

    // stage 4: strict tests against all four lines
    logic                        skin;
    logic [spc_pkg::LEVEL_W-1:0] level_next, level_reg;

    always_comb
    begin
        skin = (up1_reg < cr_q16_reg) && (up2_reg < cr_q16_reg)
            && (dn1_reg > cr_q16_reg) && (dn2_reg > cr_q16_reg);
        if (!skin)
            level_next = spc_pkg::LEVEL_NONE;
        else if (near_reg)
            level_next = spc_pkg::LEVEL_NEAR;
        else
            level_next = spc_pkg::LEVEL_FAR;
    end

    always_ff @(posedge clk)
    begin
        if (en4)
            level_reg <= level_next;
    end

    assign m_tvalid = v4_reg;
    assign m_tdata  = {6'b0,
                       (level_reg == spc_pkg::LEVEL_NEAR) ? spc_pkg::MASK_ON : spc_pkg::MASK_OFF,
                       level_reg};

endmodule

/* tb/sv/tb.sv */
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import spc_pkg::*;

    // Line slopes, Q8; the block is built with the same values
    localparam int SLOPE_UP1   = 256;
    localparam int SLOPE_UP2   = 256;
    localparam int SLOPE_DOWN1 = 256;
    localparam int SLOPE_DOWN2 = 256;

    // BT.601 full-range coefficients, Q16
    localparam longint LUMA_B = 7471;
    localparam longint LUMA_G = 38470;
    localparam longint LUMA_R = 19595;
    localparam longint CR_B   = 5328;
    localparam longint CR_G   = 27440;
    localparam longint CR_R   = 32768;
    localparam longint CB_B   = 32768;
    localparam longint CB_G   = 21712;
    localparam longint CB_R   = 11056;
    localparam longint CHROMA_BIAS = 128 * 65536;
    localparam longint HALF_LSB    = 128;
    localparam longint Q8_ONE      = 256;
    localparam longint NEAR_LIMIT  = 15 * 256;

    localparam int OFS_MIN = -262144;
    localparam int OFS_MAX = 262143;

    // Indexes past the register list
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LAST  = 3'd7;

    typedef struct {
        logic [LEVEL_W-1:0] level;
        logic [MASK_W-1:0]  mask;
    } skin_class_t;

    typedef enum {ROW_WRITE, ROW_PIXEL} row_kind_t;

    typedef struct {
        row_kind_t            kind;
        logic [CFG_IDX_W-1:0] idx;
        int                   value;
        logic [CHAN_W-1:0]    blue;
        logic [CHAN_W-1:0]    green;
        logic [CHAN_W-1:0]    red;
        bit                   typed;
        logic [LEVEL_W-1:0]   level;
        logic [MASK_W-1:0]    mask;
    } plan_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [23:0]           s_tdata = '0;    // blue, green, red
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [15:0]           m_tdata;         // skin_level, mask_byte, zero pad
    logic                  cfg_wen = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    longint      line_ofs [4];
    int          luma_ref;
    skin_class_t pending_classes [$];
    int          errors = 0;
    int          src_idle_pct = 37;
    int          sink_stall_pct = 83;
    int          src_pct_by_phase [3] = '{37, 83, 0};
    int          sink_pct_by_phase [3] = '{83, 37, 0};

    plan_row_t directed_rows [] = '{
        // straight after reset the two pairs of lines exclude each other
        '{ROW_PIXEL, REG_UPPER_LINE1, 0, 8'd0, 8'd0, 8'd0, 1'b1, LEVEL_NONE, MASK_OFF},
        '{ROW_PIXEL, REG_UPPER_LINE1, 0, 8'd255, 8'd255, 8'd255, 1'b1, LEVEL_NONE, MASK_OFF},
        '{ROW_PIXEL, REG_UPPER_LINE1, 0, 8'd0, 8'd0, 8'd255, 1'b1, LEVEL_NONE, MASK_OFF},
        // open the window as far as it goes
        '{ROW_WRITE, REG_UPPER_LINE1, OFS_MIN, 8'd0, 8'd0, 8'd0, 1'b0, LEVEL_NONE, MASK_OFF},
        '{ROW_WRITE, REG_UPPER_LINE2, OFS_MIN, 8'd0, 8'd0, 8'd0, 1'b0, LEVEL_NONE, MASK_OFF},
        '{ROW_WRITE, REG_LOWER_LINE1, OFS_MAX, 8'd0, 8'd0, 8'd0, 1'b0, LEVEL_NONE, MASK_OFF},
        '{ROW_WRITE, REG_LOWER_LINE2, OFS_MAX, 8'd0, 8'd0, 8'd0, 1'b0, LEVEL_NONE, MASK_OFF},
        '{ROW_WRITE, REG_LUMA_REF, 0, 8'd0, 8'd0, 8'd0, 1'b0, LEVEL_NONE, MASK_OFF},
        '{ROW_PIXEL, REG_UPPER_LINE1, 0, 8'd0, 8'd0, 8'd0, 1'b1, LEVEL_NEAR, MASK_ON},
        '{ROW_PIXEL, REG_UPPER_LINE1, 0, 8'd255, 8'd255, 8'd255, 1'b1, LEVEL_FAR, MASK_OFF},
        '{ROW_PIXEL, REG_UPPER_LINE1, 0, 8'd255, 8'd0, 8'd0, 1'b0, LEVEL_NONE, MASK_OFF},
        '{ROW_PIXEL, REG_UPPER_LINE1, 0, 8'd0, 8'd255, 8'd0, 1'b0, LEVEL_NONE, MASK_OFF},
        '{ROW_PIXEL, REG_UPPER_LINE1, 0, 8'd0, 8'd0, 8'd255, 1'b0, LEVEL_NONE, MASK_OFF},
        '{ROW_WRITE, REG_LUMA_REF, 255, 8'd0, 8'd0, 8'd0, 1'b0, LEVEL_NONE, MASK_OFF},
        '{ROW_PIXEL, REG_UPPER_LINE1, 0, 8'd255, 8'd255, 8'd255, 1'b1, LEVEL_NEAR, MASK_ON},
        '{ROW_PIXEL, REG_UPPER_LINE1, 0, 8'd0, 8'd0, 8'd0, 1'b1, LEVEL_FAR, MASK_OFF},
        // shut the window from below
        '{ROW_WRITE, REG_UPPER_LINE1, OFS_MAX, 8'd0, 8'd0, 8'd0, 1'b0, LEVEL_NONE, MASK_OFF},
        '{ROW_PIXEL, REG_UPPER_LINE1, 0, 8'd128, 8'd128, 8'd128, 1'b1, LEVEL_NONE, MASK_OFF},
        '{ROW_PIXEL, REG_UPPER_LINE1, 0, 8'd0, 8'd0, 8'd255, 1'b1, LEVEL_NONE, MASK_OFF},
        // grey lands exactly on Cr = Cb with luma equal to the channel value;
        // place the lines one LSB either side of it
        '{ROW_WRITE, REG_UPPER_LINE1, -1, 8'd0, 8'd0, 8'd0, 1'b0, LEVEL_NONE, MASK_OFF},
        '{ROW_WRITE, REG_UPPER_LINE2, -1, 8'd0, 8'd0, 8'd0, 1'b0, LEVEL_NONE, MASK_OFF},
        '{ROW_WRITE, REG_LOWER_LINE1, 1, 8'd0, 8'd0, 8'd0, 1'b0, LEVEL_NONE, MASK_OFF},
        '{ROW_WRITE, REG_LOWER_LINE2, 1, 8'd0, 8'd0, 8'd0, 1'b0, LEVEL_NONE, MASK_OFF},
        '{ROW_WRITE, REG_LUMA_REF, 100, 8'd0, 8'd0, 8'd0, 1'b0, LEVEL_NONE, MASK_OFF},
        '{ROW_PIXEL, REG_UPPER_LINE1, 0, 8'd100, 8'd100, 8'd100, 1'b1, LEVEL_NEAR, MASK_ON},
        '{ROW_PIXEL, REG_UPPER_LINE1, 0, 8'd114, 8'd114, 8'd114, 1'b1, LEVEL_NEAR, MASK_ON},
        '{ROW_PIXEL, REG_UPPER_LINE1, 0, 8'd115, 8'd115, 8'd115, 1'b1, LEVEL_FAR, MASK_OFF},
        '{ROW_PIXEL, REG_UPPER_LINE1, 0, 8'd86, 8'd86, 8'd86, 1'b1, LEVEL_NEAR, MASK_ON},
        '{ROW_PIXEL, REG_UPPER_LINE1, 0, 8'd85, 8'd85, 8'd85, 1'b1, LEVEL_FAR, MASK_OFF},
        // Cr on a lower-bound line, then on an upper-bound line
        '{ROW_WRITE, REG_UPPER_LINE1, 0, 8'd0, 8'd0, 8'd0, 1'b0, LEVEL_NONE, MASK_OFF},
        '{ROW_PIXEL, REG_UPPER_LINE1, 0, 8'd100, 8'd100, 8'd100, 1'b1, LEVEL_NONE, MASK_OFF},
        '{ROW_WRITE, REG_UPPER_LINE1, -1, 8'd0, 8'd0, 8'd0, 1'b0, LEVEL_NONE, MASK_OFF},
        '{ROW_WRITE, REG_LOWER_LINE2, 0, 8'd0, 8'd0, 8'd0, 1'b0, LEVEL_NONE, MASK_OFF},
        '{ROW_PIXEL, REG_UPPER_LINE1, 0, 8'd100, 8'd100, 8'd100, 1'b1, LEVEL_NONE, MASK_OFF},
        // restore the second lower line; writes past the register list must leave everything alone
        '{ROW_WRITE, REG_LOWER_LINE2, 1, 8'd0, 8'd0, 8'd0, 1'b0, LEVEL_NONE, MASK_OFF},
        '{ROW_WRITE, REG_SPARE_FIRST, OFS_MIN, 8'd0, 8'd0, 8'd0, 1'b0, LEVEL_NONE, MASK_OFF},
        '{ROW_WRITE, REG_SPARE_LAST, OFS_MAX, 8'd0, 8'd0, 8'd0, 1'b0, LEVEL_NONE, MASK_OFF},
        '{ROW_PIXEL, REG_UPPER_LINE1, 0, 8'd100, 8'd100, 8'd100, 1'b1, LEVEL_NEAR, MASK_ON},
        '{ROW_PIXEL, REG_UPPER_LINE1, 0, 8'd30, 8'd60, 8'd200, 1'b0, LEVEL_NONE, MASK_OFF},
        '{ROW_PIXEL, REG_UPPER_LINE1, 0, 8'd200, 8'd100, 8'd40, 1'b0, LEVEL_NONE, MASK_OFF}
    };

    skin_pixel_classifier #(
        .UP_SLOPE1_Q8   (SLOPE_UP1),
        .UP_SLOPE2_Q8   (SLOPE_UP2),
        .DOWN_SLOPE1_Q8 (SLOPE_DOWN1),
        .DOWN_SLOPE2_Q8 (SLOPE_DOWN2)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic skin_class_t classify_pixel(input logic [CHAN_W-1:0] b,
                                                   input logic [CHAN_W-1:0] g,
                                                   input logic [CHAN_W-1:0] r);
        longint      lb;
        longint      lg;
        longint      lr;
        longint      y_q8;
        longint      cr_q8;
        longint      cb_q8;
        longint      cr_q16;
        longint      luma_gap;
        bit          skin;
        skin_class_t c;
        lb = longint'(b);
        lg = longint'(g);
        lr = longint'(r);
        // every sum is non-negative, so the shift rounds to nearest
        y_q8  = (LUMA_B * lb + LUMA_G * lg + LUMA_R * lr + HALF_LSB) >>> 8;
        cr_q8 = (CHROMA_BIAS - CR_B * lb - CR_G * lg + CR_R * lr + HALF_LSB) >>> 8;
        cb_q8 = (CHROMA_BIAS + CB_B * lb - CB_G * lg - CB_R * lr + HALF_LSB) >>> 8;
        cr_q16 = cr_q8 * Q8_ONE;
        skin = (SLOPE_UP1 * cb_q8 + line_ofs[REG_UPPER_LINE1] * Q8_ONE < cr_q16) &&
               (SLOPE_UP2 * cb_q8 + line_ofs[REG_UPPER_LINE2] * Q8_ONE < cr_q16) &&
               (SLOPE_DOWN1 * cb_q8 + line_ofs[REG_LOWER_LINE1] * Q8_ONE > cr_q16) &&
               (SLOPE_DOWN2 * cb_q8 + line_ofs[REG_LOWER_LINE2] * Q8_ONE > cr_q16);
        c.level = LEVEL_NONE;
        c.mask  = MASK_OFF;
        if (skin)
        begin
            luma_gap = y_q8 - luma_ref * Q8_ONE;
            if (luma_gap < 0)
                luma_gap = -luma_gap;
            if (luma_gap < NEAR_LIMIT)
            begin
                c.level = LEVEL_NEAR;
                c.mask  = MASK_ON;
            end
            else
                c.level = LEVEL_FAR;
        end
        return c;
    endfunction

    function automatic logic [CHAN_W-1:0] clamp_channel(input int v);
        if (v < 0)
            return 8'd0;
        if (v > 255)
            return 8'd255;
        return v[CHAN_W-1:0];
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t: %s mismatch: got %0d, expected %0d", $realtime, what, got, want);
        errors++;
    endtask

    // Drain the pipeline, then write one register and mirror it
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        logic signed [CFG_DATA_W-1:0] v19;
        v19 = value[CFG_DATA_W-1:0];
        s_tvalid <= 1'b0;
        while (pending_classes.size() != 0)
            @(posedge clk);
        cfg_wen   <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= v19;
        @(posedge clk);
        cfg_wen <= 1'b0;
        case (idx)
            REG_UPPER_LINE1: line_ofs[REG_UPPER_LINE1] = longint'(v19);
            REG_UPPER_LINE2: line_ofs[REG_UPPER_LINE2] = longint'(v19);
            REG_LOWER_LINE1: line_ofs[REG_LOWER_LINE1] = longint'(v19);
            REG_LOWER_LINE2: line_ofs[REG_LOWER_LINE2] = longint'(v19);
            REG_LUMA_REF:    luma_ref = int'(v19[LUMA_REF_W-1:0]);
            default: ;
        endcase
        @(posedge clk);
    endtask

    // Hold the request until taken, then maybe idle; valid stays high otherwise
    task automatic send_pixel(input logic [CHAN_W-1:0] b, input logic [CHAN_W-1:0] g,
                              input logic [CHAN_W-1:0] r, input skin_class_t want);
        s_tvalid <= 1'b1;
        s_tdata  <= {r, g, b};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pending_classes.push_back(want);
        if ($urandom_range(0, 99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(0, 99) < src_idle_pct)
                @(posedge clk);
        end
    endtask

    always @(posedge clk)
    begin : result_check
        skin_class_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_classes.size() == 0)
                report_mismatch("unrequested result", int'(m_tdata), -1);
            else
            begin
                want = pending_classes.pop_front();
                if (m_tdata[1:0] !== want.level)
                    report_mismatch("skin_level", int'(m_tdata[1:0]), int'(want.level));
                if (m_tdata[9:2] !== want.mask)
                    report_mismatch("mask_byte", int'(m_tdata[9:2]), int'(want.mask));
            end
        end
        m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end

    initial
    begin
        #2ms;
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        plan_row_t   row;
        skin_class_t want;
        int          base;
        logic [CHAN_W-1:0] pb;
        logic [CHAN_W-1:0] pg;
        logic [CHAN_W-1:0] pr;

        foreach (line_ofs[i])
            line_ofs[i] = 0;
        luma_ref = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            row = directed_rows[i];
            if (row.kind == ROW_WRITE)
                write_reg(row.idx, row.value);
            else
            begin
                if (row.typed)
                begin
                    want.level = row.level;
                    want.mask  = row.mask;
                end
                else
                    want = classify_pixel(row.blue, row.green, row.red);
                send_pixel(row.blue, row.green, row.red, want);
            end
        end

        for (int phase = 0; phase < 3; phase++)
        begin
            src_idle_pct   = src_pct_by_phase[phase];
            sink_stall_pct = sink_pct_by_phase[phase];
            // a window round typical skin chroma, Cr a little above Cb
            write_reg(REG_UPPER_LINE1, -int'($urandom_range(0, 7680)));
            write_reg(REG_UPPER_LINE2, int'($urandom_range(0, 5120)) - 2560);
            write_reg(REG_LOWER_LINE1, int'($urandom_range(7680, 23040)));
            write_reg(REG_LOWER_LINE2, int'($urandom_range(5120, 20480)));
            write_reg(REG_LUMA_REF, int'($urandom_range(0, 255)));
            repeat (130)
            begin
                case ($urandom_range(0, 9))
                    0:
                    begin
                        pg = CHAN_W'($urandom_range(0, 255));
                        pb = pg;
                        pr = pg;
                    end
                    1, 2, 3:
                    begin
                        pb = CHAN_W'($urandom_range(0, 255));
                        pg = CHAN_W'($urandom_range(0, 255));
                        pr = CHAN_W'($urandom_range(0, 255));
                    end
                    default:
                    begin
                        // reddish pixel with luma close to the reference
                        base = luma_ref + int'($urandom_range(0, 40)) - 20;
                        pg = clamp_channel(base);
                        pr = clamp_channel(base + int'($urandom_range(0, 50)));
                        pb = clamp_channel(base - int'($urandom_range(0, 50)));
                    end
                endcase
                send_pixel(pb, pg, pr, classify_pixel(pb, pg, pr));
            end
        end

        s_tvalid <= 1'b0;
        while (pending_classes.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

/* filelist.f */
rtl/spc_pkg.sv
rtl/skin_pixel_classifier.sv
tb/sv/tb.sv
